/* rtl/mses_pkg.sv */
// Shared types and constants for the merge sort engine.
// Used by mses_ram and merge_sort_engine_core; depends on nothing.
package mses_pkg;

  // Width of one list element.
  localparam int unsigned DATA_W = 32;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_COLLECT = 4'b0001,
    ST_GROUP   = 4'b0010,
    ST_MERGE   = 4'b0100,
    ST_DRAIN   = 4'b1000
  } state_t;

endpackage

/* rtl/merge_sort_engine_core.sv */
// Top level of the merge sort engine: list collection, bottom-up merge
// sequencer over two ping-pong banks, and the result drain. Uses mses_pkg, mses_ram.
//
//   Channel | Ports                                      | Flow
//   --------+--------------------------------------------+-----------------
//   in      | in_valid in_ready in_value in_last         | list elements in
//   out     | out_valid out_ready out_value out_last     | sorted items out
//           | out_overflow                               |
//
// Collection takes one item per cycle. Sorting a list of n items runs
// ceil(log2 n) passes; each pass latches the bounds of each pair of runs
// in turn and then merges that pair into the other bank.
// The drain then gives one item per cycle while out_ready stays high.
// Reset clears the sequencer and counters; the banks need no clearing pass.
// A stalled output holds its item; at most one drain read waits until it moves on.
module merge_sort_engine_core #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [mses_pkg::DATA_W-1:0] in_value,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [mses_pkg::DATA_W-1:0] out_value,
  output logic                               out_last,
  output logic                               out_overflow
);
  import mses_pkg::*;

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);
  localparam logic [CW-1:0] ONE     = CW'(1);

  state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] width_r, width_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] out_cnt_r, out_cnt_nxt;
  logic          parity_r, parity_nxt;
  logic          ovf_r, ovf_nxt;
  logic          list_ovf_r, list_ovf_nxt;
  logic          pending_r, pending_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  // Bank signals.
  logic              a_wr_en, b_wr_en, rd_en;
  logic [AW-1:0]     a_wr_addr, rd_addr_a, rd_addr_b;
  logic [DATA_W-1:0] a_wr_data;
  logic [DATA_W-1:0] a_q_a, a_q_b, b_q_a, b_q_b;
  logic [DATA_W-1:0] src_a, src_b, merge_data;

  // Merge and run-bound helpers.
  logic          room, collect_wr, a_ok, b_ok, take_a;
  logic          out_slot_free, drain_issue, drain_load;
  logic [CW:0]   sum1, sum2, width2;
  logic [CW-1:0] mid_c, hi_c;

  assign in_ready      = (state_r == ST_COLLECT);
  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_last      = out_last_r;
  assign out_overflow  = out_ovf_r;

  assign room       = (count_r < MAX_CNT);
  assign collect_wr = in_ready && in_valid && room;

  // Source bank alternates each pass; bank A holds the list before sorting.
  assign src_a = parity_r ? b_q_a : a_q_a;
  assign src_b = parity_r ? b_q_b : a_q_b;

  // Heads of the left and right runs, and the stable pick of the smaller one.
  assign a_ok       = (i_r < mid_r);
  assign b_ok       = (j_r < hi_r);
  assign take_a     = a_ok && (!b_ok || ($signed(src_a) <= $signed(src_b)));
  assign merge_data = take_a ? src_a : src_b;

  // Bounds of the next pair of runs, clipped at the list length.
  assign sum1   = {1'b0, lo_r} + {1'b0, width_r};
  assign sum2   = sum1 + {1'b0, width_r};
  assign mid_c  = (sum1 < {1'b0, n_r}) ? sum1[CW-1:0] : n_r;
  assign hi_c   = (sum2 < {1'b0, n_r}) ? sum2[CW-1:0] : n_r;
  assign width2 = {width_r, 1'b0};

  // Drain handshake with the output register.
  assign out_slot_free = !out_valid_r || out_ready;
  assign drain_issue   = (state_r == ST_DRAIN) && (rd_ptr_r != n_r)
                         && (!pending_r || out_slot_free);
  assign drain_load    = (state_r == ST_DRAIN) && pending_r && out_slot_free;

  // Bank write and read ports.
  always_comb begin
    a_wr_en   = collect_wr || ((state_r == ST_MERGE) && parity_r);
    b_wr_en   = (state_r == ST_MERGE) && !parity_r;
    a_wr_addr = collect_wr ? count_r[AW-1:0] : k_r[AW-1:0];
    a_wr_data = collect_wr ? in_value : merge_data;
    rd_en     = 1'b0;
    rd_addr_a = rd_ptr_r[AW-1:0];
    rd_addr_b = rd_ptr_r[AW-1:0];
    unique case (state_r)
      ST_GROUP: begin
        rd_en     = 1'b1;
        rd_addr_a = lo_r[AW-1:0];
        rd_addr_b = mid_c[AW-1:0];
      end
      ST_MERGE: begin
        rd_en     = 1'b1;
        rd_addr_a = i_nxt[AW-1:0];
        rd_addr_b = j_nxt[AW-1:0];
      end
      ST_DRAIN: begin
        rd_en = drain_issue;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    width_nxt     = width_r;
    lo_nxt        = lo_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    rd_ptr_nxt    = rd_ptr_r;
    out_cnt_nxt   = out_cnt_r;
    parity_nxt    = parity_r;
    ovf_nxt       = ovf_r;
    list_ovf_nxt  = list_ovf_r;
    pending_nxt   = pending_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;

    unique case (state_r)
      // Store items, flagging overflow; the last item starts the sort or the drain.
      ST_COLLECT: begin
        if (in_valid) begin
          if (room) begin
            count_nxt = count_r + ONE;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            n_nxt        = room ? (count_r + ONE) : count_r;
            list_ovf_nxt = ovf_r || !room;
            count_nxt    = '0;
            ovf_nxt      = 1'b0;
            parity_nxt   = 1'b0;
            width_nxt    = ONE;
            lo_nxt       = '0;
            rd_ptr_nxt   = '0;
            out_cnt_nxt  = '0;
            pending_nxt  = 1'b0;
            state_nxt    = (n_nxt > ONE) ? ST_GROUP : ST_DRAIN;
          end
        end
      end
      // Latch the run bounds and prime the heads of both runs.
      ST_GROUP: begin
        mid_nxt   = mid_c;
        hi_nxt    = hi_c;
        i_nxt     = lo_r;
        j_nxt     = mid_c;
        k_nxt     = lo_r;
        state_nxt = ST_MERGE;
      end
      // Move one item per cycle into the destination bank.
      ST_MERGE: begin
        i_nxt = take_a ? (i_r + ONE) : i_r;
        j_nxt = take_a ? j_r : (j_r + ONE);
        k_nxt = k_r + ONE;
        if (({1'b0, k_r} + {{CW{1'b0}}, 1'b1}) == {1'b0, hi_r}) begin
          state_nxt = ST_GROUP;
          if (hi_r == n_r) begin
            parity_nxt = !parity_r;
            lo_nxt     = '0;
            if (width2 >= {1'b0, n_r}) begin
              state_nxt = ST_DRAIN;
            end else begin
              width_nxt = width2[CW-1:0];
            end
          end else begin
            lo_nxt = hi_r;
          end
        end
      end
      // Read the sorted bank in order into the output register.
      ST_DRAIN: begin
        if (drain_issue) begin
          rd_ptr_nxt = rd_ptr_r + ONE;
        end
        pending_nxt = drain_issue || (pending_r && !out_slot_free);
        if (drain_load) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = src_a;
          out_last_nxt  = (out_cnt_r == (n_r - ONE));
          out_ovf_nxt   = list_ovf_r;
          out_cnt_nxt   = out_cnt_r + ONE;
          if (out_cnt_r == (n_r - ONE)) begin
            state_nxt = ST_COLLECT;
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      count_r     <= '0;
      n_r         <= '0;
      width_r     <= '0;
      lo_r        <= '0;
      mid_r       <= '0;
      hi_r        <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      rd_ptr_r    <= '0;
      out_cnt_r   <= '0;
      parity_r    <= 1'b0;
      ovf_r       <= 1'b0;
      list_ovf_r  <= 1'b0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      n_r         <= n_nxt;
      width_r     <= width_nxt;
      lo_r        <= lo_nxt;
      mid_r       <= mid_nxt;
      hi_r        <= hi_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      out_cnt_r   <= out_cnt_nxt;
      parity_r    <= parity_nxt;
      ovf_r       <= ovf_nxt;
      list_ovf_r  <= list_ovf_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // Ping-pong banks.
  mses_ram #(.DEPTH(MAX_ITEMS)) u_bank_a (
    .clk       (clk),
    .wr_en     (a_wr_en),
    .wr_addr   (a_wr_addr),
    .wr_data   (a_wr_data),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (a_q_a),
    .rd_data_b (a_q_b)
  );

  mses_ram #(.DEPTH(MAX_ITEMS)) u_bank_b (
    .clk       (clk),
    .wr_en     (b_wr_en),
    .wr_addr   (k_r[AW-1:0]),
    .wr_data   (merge_data),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (b_q_a),
    .rd_data_b (b_q_b)
  );

  // The merge write pointer never passes the end of the current pair of runs.
  a_merge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE) |-> ((k_r < hi_r) && (i_r <= mid_r) && (j_r <= hi_r)))
    else $error("merge pointer beyond run bound");

  // A bank read for the drain is outstanding only while draining.
  a_pending_drain: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> (state_r == ST_DRAIN))
    else $error("drain read outstanding outside drain");

  // The fill count never exceeds the bank depth.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("element count beyond capacity");

  // Once sorting starts, the list has at least two items and fits the bank.
  a_sort_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GROUP) |-> ((n_r > ONE) && (n_r <= MAX_CNT) && (lo_r < n_r)))
    else $error("sort started on bad list length");

endmodule

/* rtl/mses_ram.sv */
// Element bank: one write port and two read ports with registered read data.
// Depends on mses_pkg for the element width.
module mses_ram #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [mses_pkg::DATA_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr_a,
  input  logic [AW-1:0]               rd_addr_b,
  output logic [mses_pkg::DATA_W-1:0] rd_data_a,
  output logic [mses_pkg::DATA_W-1:0] rd_data_b
);
  import mses_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Both read ports return data in the cycle after the address.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for merge_sort_engine_core: sends lists of values and compares
// each sorted item with an in-bench sorting predictor.
// Depends on rtl/mses_pkg.sv and rtl/merge_sort_engine_core.sv.
`timescale 1ns / 100ps

module testbench;
  import mses_pkg::*;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned RANDOM_ITEMS = 300;
  localparam int unsigned LONG_HOLD    = 2000;
  localparam int unsigned DRAIN_MARGIN = 100;
  localparam int unsigned CYCLE_LIMIT  = 4000000;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // One sorted item as it should leave the block.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     ovf;
  } sorted_item_t;

  // One directed stimulus row; typed rows carry their own single-item answer.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     typed;
    logic signed [DATA_W-1:0] want_value;
    logic                     want_ovf;
  } stim_row_t;

  localparam int unsigned NUM_DIRECTED = 18;
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    // Single-item lists right after reset: the item comes straight back.
    '{VAL_MIN, 1'b1, 1'b1, VAL_MIN, 1'b0},
    '{VAL_MAX, 1'b1, 1'b1, VAL_MAX, 1'b0},
    '{32'sd0,  1'b1, 1'b1, 32'sd0,  1'b0},
    '{-32'sd1, 1'b1, 1'b1, -32'sd1, 1'b0},
    // Mixed signs, duplicates and both extremes in one list.
    '{32'sd5,  1'b0, 1'b0, 32'sd0, 1'b0},
    '{-32'sd1, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{32'sd5,  1'b0, 1'b0, 32'sd0, 1'b0},
    '{VAL_MAX, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{VAL_MIN, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{32'sd0,  1'b0, 1'b0, 32'sd0, 1'b0},
    '{-32'sd1, 1'b1, 1'b0, 32'sd0, 1'b0},
    // Two items in reverse order.
    '{32'sd3,  1'b0, 1'b0, 32'sd0, 1'b0},
    '{-32'sd3, 1'b1, 1'b0, 32'sd0, 1'b0},
    // Strictly descending list spanning the full range.
    '{VAL_MAX, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{32'sd1,  1'b0, 1'b0, 32'sd0, 1'b0},
    '{VAL_MIN, 1'b1, 1'b0, 32'sd0, 1'b0},
    // Equal extremes.
    '{VAL_MIN, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{VAL_MIN, 1'b1, 1'b0, 32'sd0, 1'b0}
  };

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [DATA_W-1:0] in_value;
  logic                     in_last;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_last;
  logic                     out_overflow;

  // Predictor state: the kept part of the open list and its overflow flag.
  logic signed [DATA_W-1:0] open_list [$];
  logic                     list_dropped;
  sorted_item_t             fresh_sorted [$];
  sorted_item_t             expected_items [$];

  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          long_hold_armed;
  bit          long_hold_done;

  merge_sort_engine_core #(
    .MAX_ITEMS(CAPACITY)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_value    (in_value),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_value   (out_value),
    .out_last    (out_last),
    .out_overflow(out_overflow)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Stores one accepted item; a closing item sorts the list stably into fresh_sorted.
  task automatic absorb_element(input logic signed [DATA_W-1:0] v, input logic l);
    logic signed [DATA_W-1:0] ordered [$];
    logic signed [DATA_W-1:0] key;
    int                       j;
    if (open_list.size() < CAPACITY) begin
      open_list.push_back(v);
    end else begin
      list_dropped = 1'b1;
    end
    if (l) begin
      ordered = open_list;
      // Insertion sort with a strict compare keeps equal values in arrival order.
      for (int i = 1; i < ordered.size(); i++) begin
        key = ordered[i];
        j   = i - 1;
        while (j >= 0 && ordered[j] > key) begin
          ordered[j + 1] = ordered[j];
          j--;
        end
        ordered[j + 1] = key;
      end
      foreach (ordered[k]) begin
        fresh_sorted.push_back('{ordered[k], (k == ordered.size() - 1), list_dropped});
      end
      open_list.delete();
      list_dropped = 1'b0;
    end
  endtask

  // Offers one item after a gap and records what it should produce once accepted.
  task automatic offer_item(input logic signed [DATA_W-1:0] v, input logic l,
                            input int unsigned gap, input stim_row_t row);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fresh_sorted.delete();
    absorb_element(v, l);
    if (row.typed) begin
      expected_items.push_back('{row.want_value, 1'b1, row.want_ovf});
    end else begin
      foreach (fresh_sorted[k]) expected_items.push_back(fresh_sorted[k]);
    end
    @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] draw_value(input int unsigned style);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (style)
      0: draw_value = $urandom;
      // Narrow range to force many equal values.
      1: draw_value = DATA_W'(int'($urandom_range(0, 8)) - 4);
      default: begin
        if (pick < 3) begin
          draw_value = VAL_MIN;
        end else if (pick < 6) begin
          draw_value = VAL_MAX;
        end else begin
          draw_value = $urandom;
        end
      end
    endcase
  endfunction

  // Wait for the block to return every outstanding item.
  task automatic wait_for_empty();
    while (expected_items.size() != 0) @(negedge clk);
  endtask

  // Main sequence: reset, directed rows, a full pause, then random lists.
  initial begin : sender
    stim_row_t   plain_row;
    int unsigned sent;
    int unsigned list_idx;
    int unsigned len;
    int unsigned style;
    int unsigned bucket;
    bit          burst;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_value       = '0;
    in_last        = 1'b0;
    list_dropped   = 1'b0;
    mismatch_count = 0;
    long_hold_armed = 1'b0;
    plain_row      = '0;
    sent           = 0;
    list_idx       = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      offer_item(DIRECTED[r].value, DIRECTED[r].last, $urandom_range(0, 10), DIRECTED[r]);
    end
    in_valid <= 1'b0;
    wait_for_empty();

    // The first random lists overflow the store and fill it exactly.
    long_hold_armed = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      if (list_idx == 0) begin
        len = $urandom_range(CAPACITY + 1, CAPACITY + 4);
      end else if (list_idx == 1) begin
        len = CAPACITY;
      end else begin
        bucket = $urandom_range(0, 99);
        if (bucket < 70) begin
          len = $urandom_range(1, 8);
        end else if (bucket < 85) begin
          len = $urandom_range(9, 32);
        end else if (bucket < 95) begin
          len = $urandom_range(CAPACITY - 4, CAPACITY);
        end else begin
          len = $urandom_range(CAPACITY + 1, CAPACITY + 4);
        end
      end
      style = $urandom_range(0, 2);
      burst = (list_idx == 0) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        offer_item(draw_value(style), (i == len - 1), burst ? 0 : $urandom_range(0, 10),
                   plain_row);
      end
      sent += len;
      list_idx++;
    end
    in_valid <= 1'b0;

    wait_for_empty();
    repeat (DRAIN_MARGIN) @(posedge clk);
    if (mismatch_count == 0 && expected_items.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Result side: random stalls per item, calm stretches, and one long hold-off.
  initial begin : receiver
    int unsigned gap;
    int unsigned taken;
    bit          calm;
    out_ready      = 1'b0;
    long_hold_done = 1'b0;
    taken          = 0;
    calm           = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (taken % 20 == 0) calm = ($urandom_range(0, 2) == 0);
      if (long_hold_armed && !long_hold_done) begin
        gap            = LONG_HOLD;
        long_hold_done = 1'b1;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 10);
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  // Compare each accepted item with the oldest expectation.
  always @(posedge clk) begin : result_check
    sorted_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_items.size() == 0) begin
        $display("%0t: unexpected item value %0d last %0b overflow %0b",
                 $realtime, out_value, out_last, out_overflow);
        mismatch_count++;
      end else begin
        want = expected_items.pop_front();
        if (out_value !== want.value) begin
          $display("%0t: out_value expected %0d actual %0d", $realtime, want.value, out_value);
          mismatch_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: out_last expected %0b actual %0b", $realtime, want.last, out_last);
          mismatch_count++;
        end
        if (out_overflow !== want.ovf) begin
          $display("%0t: out_overflow expected %0b actual %0b",
                   $realtime, want.ovf, out_overflow);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule

/* filelist.f */
rtl/mses_pkg.sv
rtl/mses_ram.sv
rtl/merge_sort_engine_core.sv
sim/testbench.sv
